// File: design/mirror_padded_patch_address_generator_top_assert.svh
// assertion macros shared by the checker of the patch address generator
`ifndef MIRROR_PADDED_PATCH_ADDRESS_GENERATOR_TOP_ASSERT_SVH
`define MIRROR_PADDED_PATCH_ADDRESS_GENERATOR_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MPPAG_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MPPAG_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mppag_pkg.sv
// shared types and constants of the patch address generator
`default_nettype none
package mppag_pkg;

  localparam int MAX_DIM   = 1024;
  localparam int MAX_PATCH = 8;

  localparam int DIM_W    = $clog2(MAX_DIM) + 1;   // image size register width
  localparam int PATCH_W  = $clog2(MAX_PATCH) + 1; // patch size register width
  localparam int COORD_W  = 10;
  localparam int CNT_W    = 3;
  localparam int FRAC_W   = 17;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(65536);

  // register indexes on the configuration port
  typedef enum logic [1:0] {
    REG_IMG_WIDTH    = 2'd0,
    REG_IMG_HEIGHT   = 2'd1,
    REG_PATCH_WIDTH  = 2'd2,
    REG_PATCH_HEIGHT = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0]   img_width;
    logic [DIM_W-1:0]   img_height;
    logic [PATCH_W-1:0] patch_width;
    logic [PATCH_W-1:0] patch_height;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] center_x;
    logic [COORD_W-1:0] center_y;
  } in_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [CNT_W-1:0]   patch_col;
    logic [CNT_W-1:0]   patch_row;
    logic [FRAC_W-1:0]  row_frac;
    logic [FRAC_W-1:0]  col_frac;
    logic               last;
  } out_item_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROW_START,
    ST_ROW_WAIT,
    ST_COL_START,
    ST_COL_WAIT,
    ST_EMIT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic div_start;
    logic div_col;
    logic latch_row;
    logic latch_col;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic pos_last;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: design/mppag_cfg.sv
// configuration registers behind the register port
`default_nettype none
module mppag_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mppag_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [mppag_pkg::DATA_W-1:0]  pwdata,
  output logic      [mppag_pkg::DATA_W-1:0]  prdata,
  output logic                               pready,
  output mppag_pkg::cfg_t                    cfg_o
);
  import mppag_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_IMG_WIDTH:    cfg_d.img_width    = pwdata[DIM_W-1:0];
        REG_IMG_HEIGHT:   cfg_d.img_height   = pwdata[DIM_W-1:0];
        REG_PATCH_WIDTH:  cfg_d.patch_width  = pwdata[PATCH_W-1:0];
        REG_PATCH_HEIGHT: cfg_d.patch_height = pwdata[PATCH_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.img_width    <= DIM_W'(MAX_DIM);
      cfg_q.img_height   <= DIM_W'(MAX_DIM);
      cfg_q.patch_width  <= PATCH_W'(MAX_PATCH);
      cfg_q.patch_height <= PATCH_W'(MAX_PATCH);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_IMG_WIDTH:    prdata = DATA_W'(cfg_q.img_width);
      REG_IMG_HEIGHT:   prdata = DATA_W'(cfg_q.img_height);
      REG_PATCH_WIDTH:  prdata = DATA_W'(cfg_q.patch_width);
      REG_PATCH_HEIGHT: prdata = DATA_W'(cfg_q.patch_height);
    endcase
  end

endmodule
`default_nettype wire

// File: design/mppag_div.sv
// restoring divider, one quotient bit per cycle, for the origin fractions
`default_nettype none
module mppag_div (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [mppag_pkg::DIM_W-1:0]   num_i,
  input  wire logic [mppag_pkg::DIM_W-1:0]   den_i,
  output logic                               done_o,
  output logic      [mppag_pkg::FRAC_W-1:0]  quo_o
);
  import mppag_pkg::*;

  localparam int STEPS = FRAC_W;
  localparam int STEP_W = $clog2(STEPS);

  logic              active_q, active_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DIM_W:0]    rem_q, rem_d;
  logic [DIM_W-1:0]  den_q, den_d;
  logic [FRAC_W-1:0] quo_q, quo_d;
  logic [DIM_W:0]    trial;
  logic              ge;

  // first step takes the integer bit, later steps shift in a zero
  assign trial = (cnt_q == '0) ? {1'b0, rem_q[DIM_W-1:0]} : {rem_q[DIM_W-1:0], 1'b0};
  assign ge    = trial >= {1'b0, den_q};

  always_comb begin
    active_d = active_q;
    done_d   = 1'b0;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    den_d    = den_q;
    quo_d    = quo_q;
    if (start_i) begin
      active_d = 1'b1;
      cnt_d    = '0;
      rem_d    = {1'b0, num_i};
      den_d    = den_i;
      quo_d    = '0;
    end else if (active_q) begin
      rem_d = ge ? (trial - {1'b0, den_q}) : trial;
      quo_d = {quo_q[FRAC_W-2:0], ge};
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(STEPS - 1)) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// File: design/mppag_dp.sv
// datapath: centre capture, fractions, patch counters, folding, output register
`default_nettype none
module mppag_dp (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire mppag_pkg::cfg_t      cfg_i,
  input  wire mppag_pkg::in_item_t  in_data_i,
  input  wire mppag_pkg::dp_cmd_t   cmd_i,
  output mppag_pkg::dp_sts_t        sts_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output mppag_pkg::out_item_t      out_data_o
);
  import mppag_pkg::*;

  localparam int SW = DIM_W + 2; // signed coordinate width

  // clamp an image size to 1 .. MAX_DIM
  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] x);
    logic [DIM_W-1:0] r;
    if (x == '0) r = DIM_W'(1);
    else if (x > DIM_W'(MAX_DIM)) r = DIM_W'(MAX_DIM);
    else r = x;
    return r;
  endfunction

  // clamp a patch size to 1 .. MAX_PATCH
  function automatic logic [PATCH_W-1:0] sat_patch(input logic [PATCH_W-1:0] x);
    logic [PATCH_W-1:0] r;
    if (x == '0) r = PATCH_W'(1);
    else if (x > PATCH_W'(MAX_PATCH)) r = PATCH_W'(MAX_PATCH);
    else r = x;
    return r;
  endfunction

  // single mirror fold, saturating at zero when still out of reach
  function automatic logic [COORD_W-1:0] fold(input logic signed [SW-1:0] c,
                                               input logic [DIM_W-1:0] size);
    logic signed [SW-1:0] a;
    logic signed [SW-1:0] b;
    a = (c < 0) ? -c : c;
    if (a >= $signed({2'b00, size})) b = $signed({1'b0, size, 1'b0}) - SW'(1) - a;
    else b = a;
    if (b < 0) b = '0;
    return b[COORD_W-1:0];
  endfunction

  // patch origin clamped to 0 .. size - patch + 1
  function automatic logic [DIM_W-1:0] origin(input logic [COORD_W-1:0] centre,
                                              input logic [CNT_W-1:0] off,
                                              input logic [DIM_W-1:0] size,
                                              input logic [PATCH_W-1:0] patch);
    logic signed [SW-1:0] v;
    logic signed [SW-1:0] hi;
    v  = $signed(SW'(centre)) - $signed(SW'(off));
    hi = $signed(SW'(size)) - $signed(SW'(patch)) + SW'(1);
    if (v > hi) v = hi;
    if (v < 0) v = '0;
    return v[DIM_W-1:0];
  endfunction

  logic [DIM_W-1:0]   w_sat, h_sat;
  logic [PATCH_W-1:0] pw_sat, ph_sat;
  logic [CNT_W-1:0]   off_x, off_y, pw_m1, ph_m1;
  logic [COORD_W-1:0] cx_q, cy_q;
  logic [FRAC_W-1:0]  row_frac_q, col_frac_q, quo;
  logic [CNT_W-1:0]   col_q, col_d, row_q, row_d;
  logic               out_valid_q, out_valid_d;
  out_item_t          out_q, out_d;
  logic [DIM_W-1:0]   div_num, div_den;
  logic               div_done;
  logic               at_col_end, pos_last;
  logic signed [SW-1:0] cx_pos, cy_pos;

  // saturated configuration
  assign w_sat  = sat_dim(cfg_i.img_width);
  assign h_sat  = sat_dim(cfg_i.img_height);
  assign pw_sat = sat_patch(cfg_i.patch_width);
  assign ph_sat = sat_patch(cfg_i.patch_height);
  assign off_x  = CNT_W'(pw_sat >> 1);
  assign off_y  = CNT_W'(ph_sat >> 1);
  assign pw_m1  = CNT_W'(pw_sat - PATCH_W'(1));
  assign ph_m1  = CNT_W'(ph_sat - PATCH_W'(1));

  // centre capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cx_q <= in_data_i.center_x;
      cy_q <= in_data_i.center_y;
    end
  end

  // shared divider, row fraction first then column fraction
  assign div_num = cmd_i.div_col ? origin(cx_q, off_x, w_sat, pw_sat)
                                 : origin(cy_q, off_y, h_sat, ph_sat);
  assign div_den = cmd_i.div_col ? w_sat : h_sat;

  mppag_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_row) row_frac_q <= quo;
    if (cmd_i.latch_col) col_frac_q <= quo;
  end

  // patch position counters, column fastest
  assign at_col_end = (col_q == pw_m1);
  assign pos_last   = at_col_end && (row_q == ph_m1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cmd_i.capture) begin
      col_d = '0;
      row_d = '0;
    end else if (cmd_i.emit) begin
      if (at_col_end) begin
        col_d = '0;
        row_d = pos_last ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  // folded source coordinates of the current position
  assign cx_pos = $signed(SW'(cx_q)) + $signed(SW'(col_q)) - $signed(SW'(off_x));
  assign cy_pos = $signed(SW'(cy_q)) + $signed(SW'(row_q)) - $signed(SW'(off_y));

  always_comb begin
    out_d.src_x     = fold(cx_pos, w_sat);
    out_d.src_y     = fold(cy_pos, h_sat);
    out_d.patch_col = col_q;
    out_d.patch_row = row_q;
    out_d.row_frac  = row_frac_q;
    out_d.col_frac  = col_frac_q;
    out_d.last      = pos_last;
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.emit) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      col_q       <= col_d;
      row_q       <= row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) out_q <= out_d;
  end

  assign sts_o.div_done = div_done;
  assign sts_o.pos_last = pos_last;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule
`default_nettype wire

// File: design/mppag_ctrl.sv
// controller: sequences capture, the two divisions and the patch walk
`default_nettype none
module mppag_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire mppag_pkg::dp_sts_t   sts_i,
  output mppag_pkg::dp_cmd_t        cmd_o
);
  import mppag_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ROW_START;
        end
      end
      ST_ROW_START: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_ROW_WAIT;
      end
      ST_ROW_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.latch_row = 1'b1;
          state_d         = ST_COL_START;
        end
      end
      ST_COL_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_col   = 1'b1;
        state_d         = ST_COL_WAIT;
      end
      ST_COL_WAIT: begin
        cmd_o.div_col = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.latch_col = 1'b1;
          state_d         = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.pos_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: design/mirror_padded_patch_address_generator_top.sv
// Mirror-padded patch address generator, top level.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one patch centre.
// Output channel (out_valid_o / out_ready_i / out_data_o) gives one item per
// patch position, row-major with the column fastest; last marks the final one.
// The register port sets image and patch sizes; write it only while idle.
// Before the first result of a centre, the shared divider, which takes one
// quotient bit per cycle, works out the row fraction and then the column
// fraction. Results then leave at one per cycle while the receiver is
// ready. One centre is worked on at a time; the next is taken while the
// final result still sits in the output register.
// When the receiver stalls, the output register holds its item and the patch
// walk pauses with it.
// Reset clears the controller, counters and output valid, and sets the
// registers to a 1024 by 1024 image and an 8 by 8 patch.
`default_nettype none
module mirror_padded_patch_address_generator_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire mppag_pkg::in_item_t           in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output mppag_pkg::out_item_t               out_data_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mppag_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [mppag_pkg::DATA_W-1:0]  pwdata,
  output logic      [mppag_pkg::DATA_W-1:0]  prdata,
  output logic                               pready
);
  import mppag_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  // configuration registers
  mppag_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // controller
  mppag_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath
  mppag_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// File: design/mppag_checker.sv
// port-level checker for the patch address generator, bound to the top level
`default_nettype none
`include "mirror_padded_patch_address_generator_top_assert.svh"
module mppag_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 in_valid_i,
  input wire logic                 in_ready_o,
  input wire logic                 out_valid_o,
  input wire logic                 out_ready_i,
  input wire mppag_pkg::out_item_t out_data_o
);
  import mppag_pkg::*;

  logic out_stall;
  logic in_acc;
  logic idle_pend;
  logic frac_ok;

  assign out_stall = out_valid_o && !out_ready_i;
  assign in_acc    = in_valid_i && in_ready_o;
  assign idle_pend = out_valid_o && in_ready_o;
  assign frac_ok   = (out_data_o.row_frac <= FRAC_ONE) && (out_data_o.col_frac <= FRAC_ONE);

  // a stalled result stays valid and holds
  `MPPAG_ASSERT_NXT(a_hold_valid, clk_i, rst_ni, out_stall, out_valid_o, "stalled item dropped")
  `MPPAG_ASSERT_NXT(a_hold_data, clk_i, rst_ni, out_stall, $stable(out_data_o), "item changed")

  // one centre at a time: no new item right after one is accepted
  `MPPAG_ASSERT_NXT(a_busy_next, clk_i, rst_ni, in_acc, !in_ready_o, "input taken while busy")

  // while ready for a centre, a pending result can only be the final one
  `MPPAG_ASSERT_IMP(a_idle_last, clk_i, rst_ni, idle_pend, out_data_o.last, "non-final item")

  // fractions never exceed one
  `MPPAG_ASSERT_IMP(a_frac_range, clk_i, rst_ni, out_valid_o, frac_ok, "fraction above one")

endmodule

bind mirror_padded_patch_address_generator_top mppag_checker u_mppag_checker (.*);
`default_nettype wire

// File: tb/tb.sv
// testbench for the mirror-padded patch address generator
`default_nettype none
module tb;
  import mppag_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 60;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #1 clk_i = ~clk_i;

  // stream channels
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // register port
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mirror_padded_patch_address_generator_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // shadow of the size registers, reset values
  cfg_t sizes = '{img_width: 11'd1024, img_height: 11'd1024,
                  patch_width: 4'd8, patch_height: 4'd8};

  out_item_t   pending_positions[$];
  int unsigned send_gap_pct = 19;
  int unsigned recv_stall_pct = 48;
  int unsigned error_cnt = 0;
  int unsigned cycle_cnt = 0;

  function automatic int clamp_size(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // single mirror fold, saturating at zero when out of reach
  function automatic logic [COORD_W-1:0] fold_coord(int c, int size);
    if (c < 0) c = -c;
    if (c >= size) c = 2 * size - 1 - c;
    if (c < 0) c = 0;
    return COORD_W'(c);
  endfunction

  // clamped patch origin over image size, floor q1.16
  function automatic logic [FRAC_W-1:0] origin_fraction(int centre, int offset, int size,
                                                        int patch);
    int     v;
    int     hi;
    longint q;
    v  = centre - offset;
    hi = size - patch + 1;
    if (v > hi) v = hi;
    if (v < 0) v = 0;
    q = (longint'(v) << 16) / longint'(size);
    return FRAC_W'(q);
  endfunction

  // expected walk over every patch position of one centre
  task automatic walk_patch(int cx, int cy);
    int        w;
    int        h;
    int        pw;
    int        ph;
    out_item_t pos;
    w  = clamp_size(int'(sizes.img_width), MAX_DIM);
    h  = clamp_size(int'(sizes.img_height), MAX_DIM);
    pw = clamp_size(int'(sizes.patch_width), MAX_PATCH);
    ph = clamp_size(int'(sizes.patch_height), MAX_PATCH);
    pos.row_frac = origin_fraction(cy, ph / 2, h, ph);
    pos.col_frac = origin_fraction(cx, pw / 2, w, pw);
    for (int r = 0; r < ph; r++) begin
      for (int c = 0; c < pw; c++) begin
        pos.src_y     = fold_coord(cy + r - ph / 2, h);
        pos.src_x     = fold_coord(cx + c - pw / 2, w);
        pos.patch_row = CNT_W'(r);
        pos.patch_col = CNT_W'(c);
        pos.last      = (r == ph - 1) && (c == pw - 1);
        pending_positions.push_back(pos);
      end
    end
  endtask

  // send one centre, entered and left at a falling edge
  task automatic send_center(int cx, int cy);
    in_item_t item;
    item.center_x = COORD_W'(cx);
    item.center_y = COORD_W'(cy);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (!in_ready);
    walk_patch(cx, cy);
    @(negedge clk_i);
  endtask

  // wait until every expected position has come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_positions.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // setup then access phase, register written at the access edge
  task automatic write_reg(reg_idx_e idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_IMG_WIDTH:    sizes.img_width    = value[DIM_W-1:0];
      REG_IMG_HEIGHT:   sizes.img_height   = value[DIM_W-1:0];
      REG_PATCH_WIDTH:  sizes.patch_width  = value[PATCH_W-1:0];
      REG_PATCH_HEIGHT: sizes.patch_height = value[PATCH_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_sizes(int w, int h, int pw, int ph);
    wait_idle();
    write_reg(REG_IMG_WIDTH, DATA_W'(w));
    write_reg(REG_IMG_HEIGHT, DATA_W'(h));
    write_reg(REG_PATCH_WIDTH, DATA_W'(pw));
    write_reg(REG_PATCH_HEIGHT, DATA_W'(ph));
  endtask

  // mostly legal sizes, now and then saturating ones
  function automatic int rand_image_size();
    case ($urandom_range(9))
      0: return $urandom_range(7, 0);
      1: return $urandom_range(2047, 1025);
      2: return ($urandom_range(1) != 0) ? 8 : 1024;
      default: return $urandom_range(1024, 8);
    endcase
  endfunction

  function automatic int rand_patch_size();
    case ($urandom_range(9))
      0: return ($urandom_range(1) != 0) ? 0 : $urandom_range(15, 9);
      default: return $urandom_range(8, 1);
    endcase
  endfunction

  // centre coordinate: inside, near an edge, or anywhere in the field
  function automatic int rand_coord(int size_reg);
    int s;
    int k;
    int reach;
    s     = clamp_size(size_reg, MAX_DIM);
    k     = $urandom_range(99);
    reach = (s - 1 < 8) ? s - 1 : 8;
    if (k < 15) return $urandom_range(1023, 0);
    if (k < 45) begin
      if ($urandom_range(1) != 0) return $urandom_range(reach, 0);
      return s - 1 - $urandom_range(reach, 0);
    end
    return $urandom_range(s - 1, 0);
  endfunction

  // compare one field of a result
  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_cnt++;
    end
  endtask

  // receiver stalls
  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk_i) begin
    out_item_t exp_pos;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_positions.size() == 0) begin
        $error("unexpected result: src_x %0d src_y %0d", out_data.src_x, out_data.src_y);
        error_cnt++;
      end else begin
        exp_pos = pending_positions.pop_front();
        check_field("src_x", exp_pos.src_x, out_data.src_x);
        check_field("src_y", exp_pos.src_y, out_data.src_y);
        check_field("patch_col", exp_pos.patch_col, out_data.patch_col);
        check_field("patch_row", exp_pos.patch_row, out_data.patch_row);
        check_field("row_frac", exp_pos.row_frac, out_data.row_frac);
        check_field("col_frac", exp_pos.col_frac, out_data.col_frac);
        check_field("last", exp_pos.last, out_data.last);
      end
    end
  end

  // hang guard
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // corners and middle at the reset sizes
  task automatic test_reset_sizes();
    send_center(0, 0);
    send_center(1023, 1023);
    send_center(0, 1023);
    send_center(1023, 0);
    send_center(512, 512);
  endtask

  // single row, single column and odd patch shapes
  task automatic test_patch_shapes();
    set_sizes(1024, 1024, 1, 1);
    send_center(0, 0);
    send_center(1023, 1023);
    set_sizes(16, 8, 8, 1);
    send_center(15, 0);
    set_sizes(8, 16, 1, 8);
    send_center(0, 15);
    set_sizes(9, 11, 3, 5);
    send_center(4, 5);
    send_center(8, 10);
  endtask

  // zero and oversized registers saturate
  task automatic test_size_saturation();
    set_sizes(0, 2047, 0, 15);
    send_center(0, 0);
    send_center(1023, 1023);
    set_sizes(2047, 0, 15, 0);
    send_center(5, 0);
  endtask

  // image smaller than patch, centre outside the image, full fraction
  task automatic test_out_of_reach();
    set_sizes(5, 3, 8, 8);
    send_center(2, 1);
    send_center(4, 2);
    set_sizes(8, 8, 8, 8);
    send_center(1023, 1023);
    send_center(700, 3);
    set_sizes(8, 8, 1, 1);
    send_center(20, 8);
  endtask

  // random centres under random sizes, three idling phases
  task automatic test_random_walks();
    for (int phase = 0; phase < 3; phase++) begin
      wait_idle();
      case (phase)
        0: begin send_gap_pct = 19; recv_stall_pct = 48; end
        1: begin send_gap_pct = 48; recv_stall_pct = 19; end
        default: begin send_gap_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 100; n++) begin
        if (n % 20 == 0)
          set_sizes(rand_image_size(), rand_image_size(), rand_patch_size(),
                    rand_patch_size());
        send_center(rand_coord(int'(sizes.img_width)), rand_coord(int'(sizes.img_height)));
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_sizes();
    test_patch_shapes();
    test_size_saturation();
    test_out_of_reach();
    test_random_walks();
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (error_cnt == 0 && pending_positions.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
`default_nettype wire
